### sv/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types and codes for the cross-correlation lag engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ccl_pkg;

   localparam int LAG_W      = 6;
   localparam int CORR_W     = 43;
   localparam int STATUS_W   = 2;
   localparam int MODE_W     = 2;
   localparam int MAXLAG_W   = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [1:0] {
      CMD_PUSH_X  = 2'd0,
      CMD_PUSH_Y  = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;

   localparam logic [MODE_W-1:0] MODE_UNSCALED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BIASED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNBIASED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LAG    = 1'b1;

   // per-run control handed from front to back
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [MAXLAG_W-1:0] max_lag;
      logic [STATUS_W-1:0] status;
   } job_ctl_type;

   typedef struct packed {
      logic signed [LAG_W-1:0]  lag;
      logic signed [CORR_W-1:0] corr_re;
      logic signed [CORR_W-1:0] corr_im;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } rsp_type;

endpackage

`default_nettype wire

### sv/ccl_ram.sv
// ----------------------------------------------------------------------------
// ccl_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/ccl_fifo.sv
// ----------------------------------------------------------------------------
// ccl_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/ccl_front.sv
// ----------------------------------------------------------------------------
// ccl_front
// Takes items, keeps lengths and the drop flag, writes the sample memories
// and queues compute runs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_front #(
   parameter int MAX_LEN     = 1024,
   parameter int MAX_LAG     = 31,
   parameter int SAMPLE_BITS = 16,
   parameter int LEN_W       = 11,
   parameter int AW          = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [1:0]                           req_command,
   input  wire logic [SAMPLE_BITS-1:0]               req_sample_re,
   input  wire logic [SAMPLE_BITS-1:0]               req_sample_im,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ccl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ccl_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic                                 back_busy,
   input  wire logic                                 job_full,
   output logic                                      job_push,
   output ccl_pkg::job_ctl_type                      job_ctl,
   output logic      [LEN_W-1:0]                     job_n,
   output logic      [LEN_W-1:0]                     job_xlen,
   output logic      [LEN_W-1:0]                     job_ylen,
   output logic                                      xw_en,
   output logic                                      yw_en,
   output logic      [AW-1:0]                        xw_addr,
   output logic      [AW-1:0]                        yw_addr,
   output logic      [2*SAMPLE_BITS-1:0]             w_data
);

   logic [LEN_W-1:0]                 x_len_ff, x_len_in, y_len_ff, y_len_in;
   logic                             dropped_ff, dropped_in;
   logic [ccl_pkg::MODE_W-1:0]       mode_ff;
   logic [ccl_pkg::MAXLAG_W-1:0]     max_lag_ff;
   ccl_pkg::cmd_type                 cmd;
   logic                             accept;

   assign cmd       = ccl_pkg::cmd_type'(req_command);
   // a clear must not pull memory from under a run still reading it
   assign req_full  = job_full || ((cmd == ccl_pkg::CMD_CLEAR) && back_busy);
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;
   assign w_data    = {req_sample_re, req_sample_im};
   assign xw_addr   = x_len_ff[AW-1:0];
   assign yw_addr   = y_len_ff[AW-1:0];

   assign job_n    = (x_len_ff > y_len_ff) ? x_len_ff : y_len_ff;
   assign job_xlen = x_len_ff;
   assign job_ylen = y_len_ff;

   always_comb begin
      job_ctl.mode    = mode_ff;
      job_ctl.max_lag = (max_lag_ff > ccl_pkg::MAXLAG_W'(MAX_LAG)) ?
                        ccl_pkg::MAXLAG_W'(MAX_LAG) : max_lag_ff;
      if ((x_len_ff == '0) || (y_len_ff == '0)) begin
         job_ctl.status = ccl_pkg::STAT_EMPTY;
      end else if (dropped_ff) begin
         job_ctl.status = ccl_pkg::STAT_DROPPED;
      end else begin
         job_ctl.status = ccl_pkg::STAT_OK;
      end
   end

   always_comb begin
      x_len_in   = x_len_ff;
      y_len_in   = y_len_ff;
      dropped_in = dropped_ff;
      xw_en      = 1'b0;
      yw_en      = 1'b0;
      job_push   = 1'b0;
      if (accept) begin
         unique case (cmd)
            ccl_pkg::CMD_PUSH_X: begin
               if (x_len_ff == LEN_W'(MAX_LEN)) begin
                  dropped_in = 1'b1;
               end else begin
                  xw_en    = 1'b1;
                  x_len_in = x_len_ff + LEN_W'(1);
               end
            end
            ccl_pkg::CMD_PUSH_Y: begin
               if (y_len_ff == LEN_W'(MAX_LEN)) begin
                  dropped_in = 1'b1;
               end else begin
                  yw_en    = 1'b1;
                  y_len_in = y_len_ff + LEN_W'(1);
               end
            end
            ccl_pkg::CMD_COMPUTE: begin
               job_push = 1'b1;
            end
            ccl_pkg::CMD_CLEAR: begin
               x_len_in   = '0;
               y_len_in   = '0;
               dropped_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_len_ff   <= '0;
         y_len_ff   <= '0;
         dropped_ff <= 1'b0;
         mode_ff    <= ccl_pkg::MODE_UNSCALED;
         max_lag_ff <= ccl_pkg::MAXLAG_W'(31);
      end else begin
         x_len_ff   <= x_len_in;
         y_len_ff   <= y_len_in;
         dropped_ff <= dropped_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == ccl_pkg::CSR_SCALE_MODE) begin
               mode_ff <= csr_wdata[ccl_pkg::MODE_W-1:0];
            end else begin
               max_lag_ff <= csr_wdata[ccl_pkg::MAXLAG_W-1:0];
            end
         end
      end
   end

endmodule

`default_nettype wire

### sv/ccl_back.sv
// ----------------------------------------------------------------------------
// ccl_back
// Runs one queued compute job: per lag a multiply-accumulate walk of both
// memories, a bit-serial divide for scaling, saturation and result push.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_back #(
   parameter int MAX_LEN     = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int LEN_W       = 11,
   parameter int AW          = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_valid,
   output logic                              job_pop,
   input  wire ccl_pkg::job_ctl_type         job_ctl,
   input  wire logic [LEN_W-1:0]             job_n,
   input  wire logic [LEN_W-1:0]             job_xlen,
   input  wire logic [LEN_W-1:0]             job_ylen,
   output logic                              busy,
   output logic                              rd_en,
   output logic      [AW-1:0]                x_rd_addr,
   output logic      [AW-1:0]                y_rd_addr,
   input  wire logic [2*SAMPLE_BITS-1:0]     x_rd_data,
   input  wire logic [2*SAMPLE_BITS-1:0]     y_rd_data,
   input  wire logic                         res_full,
   output logic                              res_push,
   output ccl_pkg::rsp_type                  res_data
);

   localparam int SB    = SAMPLE_BITS;
   localparam int SW    = LEN_W + 2;
   localparam int LW    = ccl_pkg::LAG_W;
   localparam int ACC_W = 2 * SB + 2 + $clog2(MAX_LEN);
   localparam int RES_W = ACC_W + 1;
   localparam int EXT_W = ((RES_W > ccl_pkg::CORR_W) ? RES_W : ccl_pkg::CORR_W) + 1;
   localparam int CNT_W = $clog2(ACC_W + 1);
   localparam logic signed [EXT_W-1:0] SAT_HI =
      (EXT_W'(1) << (ccl_pkg::CORR_W - 1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SETUP = 6'b000010,
      S_MAC   = 6'b000100,
      S_DRAIN = 6'b001000,
      S_DIV   = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   ccl_pkg::job_ctl_type      ctl_ff;
   logic [LEN_W-1:0]          n_ff, xlen_ff, ylen_ff;
   logic signed [LW-1:0]      k_ff;
   logic signed [SW-1:0]      i_ff, hi_ff;
   logic                      rd_v_ff, prod_v_ff;
   logic signed [2*SB-1:0]    p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [ACC_W-1:0]   acc_re_ff, acc_im_ff;
   logic [LEN_W-1:0]          d_ff;
   logic [ACC_W-1:0]          quo_re_ff, quo_im_ff;
   logic [LEN_W-1:0]          rem_re_ff, rem_im_ff;
   logic                      neg_re_ff, neg_im_ff, divide_ff;
   logic [CNT_W-1:0]          cnt_ff;

   logic signed [SW-1:0]      k_ext, n_s, lo, hi_a, hi_b, hi, ak_ext;
   logic [LW-1:0]             ak;
   logic                      zero_lag, is_last;
   logic signed [LW-1:0]      lag_top;
   logic [LEN_W-1:0]          divisor;
   logic [LEN_W:0]            rn_re, rn_im;
   logic                      ge_re, ge_im;
   logic signed [SB-1:0]      xr, xi, yr, yi;
   logic signed [RES_W-1:0]   val_re, val_im;
   logic signed [EXT_W-1:0]   ext_re, ext_im;

   assign busy    = (state_ff != S_IDLE);
   assign lag_top = LW'($signed({1'b0, ctl_ff.max_lag}));
   assign is_last = (k_ff == lag_top);

   // lag window bounds
   assign k_ext  = SW'(k_ff);
   assign ak     = k_ff[LW-1] ? LW'(-k_ff) : LW'(k_ff);
   assign ak_ext = $signed(SW'(ak));
   assign n_s    = $signed(SW'(n_ff));
   assign lo     = k_ff[LW-1] ? -k_ext : '0;
   assign hi_a   = $signed(SW'(ylen_ff)) - SW'(1);
   assign hi_b   = $signed(SW'(xlen_ff)) - SW'(1) - k_ext;
   assign hi     = (hi_b < hi_a) ? hi_b : hi_a;
   assign zero_lag = (ctl_ff.status == ccl_pkg::STAT_EMPTY) || (ak_ext >= n_s) || (hi < lo);

   always_comb begin
      if (ctl_ff.mode == ccl_pkg::MODE_BIASED) begin
         divisor = n_ff;
      end else if (ctl_ff.mode == ccl_pkg::MODE_UNBIASED) begin
         divisor = n_ff - LEN_W'(ak);
      end else begin
         divisor = LEN_W'(1);
      end
   end

   assign rd_en     = (state_ff == S_MAC);
   assign x_rd_addr = AW'(i_ff + k_ext);
   assign y_rd_addr = AW'(i_ff);

   assign xr = $signed(x_rd_data[2*SB-1:SB]);
   assign xi = $signed(x_rd_data[SB-1:0]);
   assign yr = $signed(y_rd_data[2*SB-1:SB]);
   assign yi = $signed(y_rd_data[SB-1:0]);

   // restoring divide step, one quotient bit per cycle on each part
   assign rn_re = {rem_re_ff, quo_re_ff[ACC_W-1]};
   assign rn_im = {rem_im_ff, quo_im_ff[ACC_W-1]};
   assign ge_re = (rn_re >= {1'b0, d_ff});
   assign ge_im = (rn_im >= {1'b0, d_ff});

   always_comb begin
      if (divide_ff) begin
         val_re = neg_re_ff ? -$signed({1'b0, quo_re_ff}) : $signed({1'b0, quo_re_ff});
         val_im = neg_im_ff ? -$signed({1'b0, quo_im_ff}) : $signed({1'b0, quo_im_ff});
      end else begin
         val_re = RES_W'(acc_re_ff);
         val_im = RES_W'(acc_im_ff);
      end
      ext_re = EXT_W'(val_re);
      ext_im = EXT_W'(val_im);
      if (ext_re > SAT_HI) begin
         ext_re = SAT_HI;
      end else if (ext_re < SAT_LO) begin
         ext_re = SAT_LO;
      end
      if (ext_im > SAT_HI) begin
         ext_im = SAT_HI;
      end else if (ext_im < SAT_LO) begin
         ext_im = SAT_LO;
      end
      res_data.lag     = k_ff;
      res_data.corr_re = ext_re[ccl_pkg::CORR_W-1:0];
      res_data.corr_im = ext_im[ccl_pkg::CORR_W-1:0];
      res_data.status  = ctl_ff.status;
      res_data.last    = is_last;
   end

   always_comb begin
      state_in = state_ff;
      job_pop  = 1'b0;
      res_push = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            state_in = zero_lag ? S_EMIT : S_MAC;
         end
         S_MAC: begin
            if (i_ff == hi_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = (divisor > LEN_W'(1)) ? S_DIV : S_EMIT;
            end
         end
         S_DIV: begin
            if (cnt_ff == CNT_W'(ACC_W - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = is_last ? S_IDLE : S_SETUP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= rd_en;
         prod_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= xr * yr;
      p_ii_ff <= xi * yi;
      p_ri_ff <= xi * yr;
      p_ir_ff <= xr * yi;
      if (prod_v_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(p_rr_ff) + ACC_W'(p_ii_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(p_ri_ff) - ACC_W'(p_ir_ff);
      end
      unique case (state_ff)
         S_IDLE: begin
            ctl_ff  <= job_ctl;
            n_ff    <= job_n;
            xlen_ff <= job_xlen;
            ylen_ff <= job_ylen;
            k_ff    <= -LW'($signed({1'b0, job_ctl.max_lag}));
         end
         S_SETUP: begin
            i_ff      <= lo;
            hi_ff     <= hi;
            acc_re_ff <= '0;
            acc_im_ff <= '0;
            divide_ff <= 1'b0;
         end
         S_MAC: begin
            i_ff <= i_ff + SW'(1);
         end
         S_DRAIN: begin
            d_ff      <= divisor;
            divide_ff <= (divisor > LEN_W'(1));
            cnt_ff    <= '0;
            rem_re_ff <= '0;
            rem_im_ff <= '0;
            neg_re_ff <= acc_re_ff[ACC_W-1];
            neg_im_ff <= acc_im_ff[ACC_W-1];
            quo_re_ff <= acc_re_ff[ACC_W-1] ? ACC_W'(-acc_re_ff) : ACC_W'(acc_re_ff);
            quo_im_ff <= acc_im_ff[ACC_W-1] ? ACC_W'(-acc_im_ff) : ACC_W'(acc_im_ff);
         end
         S_DIV: begin
            cnt_ff    <= cnt_ff + CNT_W'(1);
            rem_re_ff <= ge_re ? LEN_W'(rn_re - {1'b0, d_ff}) : LEN_W'(rn_re);
            rem_im_ff <= ge_im ? LEN_W'(rn_im - {1'b0, d_ff}) : LEN_W'(rn_im);
            quo_re_ff <= {quo_re_ff[ACC_W-2:0], ge_re};
            quo_im_ff <= {quo_im_ff[ACC_W-2:0], ge_im};
         end
         S_EMIT: begin
            if (!res_full && !is_last) begin
               k_ff <= k_ff + LW'(1);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/cross_correlation_lags.sv
// Load and clear items: one per cycle, no result; a clear waits while a run is active and
// every item waits while two compute runs are queued.
// Compute item: 2L+1 results; each lag runs set-up, MAC walk, drain and emit, with a
// bit-serial divide when scaled; a lag outside the data takes only set-up and emit.
// Synchronous active-high reset empties both sequences and both queues; memory keeps its data.
// ----------------------------------------------------------------------------
// cross_correlation_lags
// Complex cross-correlation over lags -L..L of two stored sequences, with
// unscaled, biased or unbiased scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_correlation_lags #(
   parameter int MAX_LEN     = 1024,
   parameter int MAX_LAG     = 31,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // item input
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic [1:0]                            req_command,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample_re,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample_im,
   // result output
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic signed [ccl_pkg::LAG_W-1:0]           rsp_lag,
   output logic signed [ccl_pkg::CORR_W-1:0]          rsp_corr_re,
   output logic signed [ccl_pkg::CORR_W-1:0]          rsp_corr_im,
   output logic      [ccl_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                       rsp_last,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ccl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [ccl_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DW    = 2 * SAMPLE_BITS;
   localparam int JOB_W = $bits(ccl_pkg::job_ctl_type) + 3 * LEN_W;
   localparam int RSP_W = $bits(ccl_pkg::rsp_type);

   // front to queue
   logic                      job_push, job_full, job_pop, job_empty;
   ccl_pkg::job_ctl_type      f_ctl, b_ctl;
   logic [LEN_W-1:0]          f_n, f_xlen, f_ylen, b_n, b_xlen, b_ylen;
   logic [JOB_W-1:0]          job_q_out;
   logic                      back_busy, run_busy;

   // memories
   logic                      xw_en, yw_en, rd_en;
   logic [AW-1:0]             xw_addr, yw_addr, x_rd_addr, y_rd_addr;
   logic [DW-1:0]             w_data, x_rd_data, y_rd_data;

   // results
   logic                      res_push, res_full;
   ccl_pkg::rsp_type          res_data, rsp_q;
   logic [RSP_W-1:0]          rsp_q_out;

   // a run is in flight while the back end works or a job still waits
   assign run_busy = back_busy || !job_empty;

   ccl_front #(
      .MAX_LEN(MAX_LEN), .MAX_LAG(MAX_LAG), .SAMPLE_BITS(SAMPLE_BITS),
      .LEN_W(LEN_W), .AW(AW)
   ) u_front (
      .clock, .reset,
      .req_push(push), .req_full(full), .req_command,
      .req_sample_re(req_sample_re), .req_sample_im(req_sample_im),
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .back_busy(run_busy), .job_full, .job_push,
      .job_ctl(f_ctl), .job_n(f_n), .job_xlen(f_xlen), .job_ylen(f_ylen),
      .xw_en, .yw_en, .xw_addr, .yw_addr, .w_data
   );

   ccl_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
      .clock, .reset,
      .push(job_push), .push_data({f_ctl, f_n, f_xlen, f_ylen}), .full(job_full),
      .pop(job_pop), .pop_data(job_q_out), .empty(job_empty)
   );

   assign {b_ctl, b_n, b_xlen, b_ylen} = job_q_out;

   ccl_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_x_ram (
      .clock, .wr_en(xw_en), .wr_addr(xw_addr), .wr_data(w_data),
      .rd_en, .rd_addr(x_rd_addr), .rd_data(x_rd_data)
   );

   ccl_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_y_ram (
      .clock, .wr_en(yw_en), .wr_addr(yw_addr), .wr_data(w_data),
      .rd_en, .rd_addr(y_rd_addr), .rd_data(y_rd_data)
   );

   ccl_back #(
      .MAX_LEN(MAX_LEN), .SAMPLE_BITS(SAMPLE_BITS), .LEN_W(LEN_W), .AW(AW)
   ) u_back (
      .clock, .reset,
      .job_valid(!job_empty), .job_pop, .job_ctl(b_ctl),
      .job_n(b_n), .job_xlen(b_xlen), .job_ylen(b_ylen),
      .busy(back_busy), .rd_en, .x_rd_addr, .y_rd_addr, .x_rd_data, .y_rd_data,
      .res_full, .res_push, .res_data
   );

   // output queue parts the engine from the consumer
   ccl_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_q (
      .clock, .reset,
      .push(res_push), .push_data(res_data), .full(res_full),
      .pop, .pop_data(rsp_q_out), .empty
   );

   assign rsp_q       = rsp_q_out;
   assign rsp_lag     = rsp_q.lag;
   assign rsp_corr_re = rsp_q.corr_re;
   assign rsp_corr_im = rsp_q.corr_im;
   assign rsp_status  = rsp_q.status;
   assign rsp_last    = rsp_q.last;

endmodule

`default_nettype wire

### sv/ccl_checker.sv
// ----------------------------------------------------------------------------
// ccl_checker
// Port-level checks on the correlation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccl_port_checks (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               empty,
   input wire logic                               pop,
   input wire logic signed [ccl_pkg::LAG_W-1:0]   rsp_lag,
   input wire logic signed [ccl_pkg::CORR_W-1:0]  rsp_corr_re,
   input wire logic signed [ccl_pkg::CORR_W-1:0]  rsp_corr_im,
   input wire logic [ccl_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic                               rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_lag) && $stable(rsp_corr_re)))
      else $error("waiting result changed");

   a_last_lag: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last) |-> !rsp_lag[ccl_pkg::LAG_W-1])
      else $error("last result with negative lag");

   a_status: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status == ccl_pkg::STAT_OK || rsp_status == ccl_pkg::STAT_EMPTY ||
                  rsp_status == ccl_pkg::STAT_DROPPED))
      else $error("bad status code");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == ccl_pkg::STAT_EMPTY) |->
         (rsp_corr_re == '0 && rsp_corr_im == '0))
      else $error("nonzero value for empty sequence");

endmodule

bind cross_correlation_lags ccl_port_checks u_port_checks (
   .clock, .reset, .empty, .pop, .rsp_lag, .rsp_corr_re, .rsp_corr_im,
   .rsp_status, .rsp_last
);

`default_nettype wire

### test/ccl_checker.sv
// ----------------------------------------------------------------------------
// ccl_checker
// Watches the item, result and register channels of the correlation engine,
// predicts every result run and compares results field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module ccl_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   input  wire logic                                  full,
   input  wire logic [1:0]                            req_command,
   input  wire logic signed [15:0]                    req_sample_re,
   input  wire logic signed [15:0]                    req_sample_im,
   input  wire logic                                  empty,
   input  wire logic                                  pop,
   input  wire logic signed [ccl_pkg::LAG_W-1:0]      rsp_lag,
   input  wire logic signed [ccl_pkg::CORR_W-1:0]     rsp_corr_re,
   input  wire logic signed [ccl_pkg::CORR_W-1:0]     rsp_corr_im,
   input  wire logic [ccl_pkg::STATUS_W-1:0]          rsp_status,
   input  wire logic                                  rsp_last,
   input  wire logic                                  csr_valid,
   input  wire logic                                  csr_ready,
   input  wire logic [ccl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [ccl_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output int                                         fail_count,
   output int                                         pending
);

   localparam int     DEPTH   = 1024;
   localparam longint CORR_HI = 64'sd4398046511103;
   localparam longint CORR_LO = -64'sd4398046511104;

   int x_re [DEPTH];
   int x_im [DEPTH];
   int y_re [DEPTH];
   int y_im [DEPTH];
   int x_len, y_len;
   bit dropped;
   logic [ccl_pkg::MODE_W-1:0]   scale_mode;
   logic [ccl_pkg::MAXLAG_W-1:0] lag_limit;

   ccl_pkg::rsp_type lag_q [$];

   function automatic logic signed [ccl_pkg::CORR_W-1:0] clamp43(longint v);
      if (v > CORR_HI) return CORR_HI[ccl_pkg::CORR_W-1:0];
      if (v < CORR_LO) return CORR_LO[ccl_pkg::CORR_W-1:0];
      return v[ccl_pkg::CORR_W-1:0];
   endfunction

   // one compute item: queue the whole run of lags
   function automatic void queue_lag_run();
      int               lim, n, k, ak, i, lo, hi;
      longint           sr, si, d;
      bit               none;
      ccl_pkg::rsp_type r;
      lim  = int'(lag_limit);
      n    = (x_len > y_len) ? x_len : y_len;
      none = (x_len == 0) || (y_len == 0);
      for (k = -lim; k <= lim; k++) begin
         ak = (k < 0) ? -k : k;
         sr = 0;
         si = 0;
         if (!none && ak < n) begin
            lo = (k < 0) ? -k : 0;
            hi = y_len - 1;
            if (x_len - 1 - k < hi) hi = x_len - 1 - k;
            for (i = lo; i <= hi; i++) begin
               sr += longint'(x_re[i+k]) * y_re[i] + longint'(x_im[i+k]) * y_im[i];
               si += longint'(x_im[i+k]) * y_re[i] - longint'(x_re[i+k]) * y_im[i];
            end
            if (scale_mode == ccl_pkg::MODE_BIASED)        d = n;
            else if (scale_mode == ccl_pkg::MODE_UNBIASED) d = n - ak;
            else                                           d = 1;
            if (d > 1) begin
               sr = sr / d;
               si = si / d;
            end
         end
         r.lag     = k[ccl_pkg::LAG_W-1:0];
         r.corr_re = clamp43(sr);
         r.corr_im = clamp43(si);
         r.status  = none ? ccl_pkg::STAT_EMPTY :
                     (dropped ? ccl_pkg::STAT_DROPPED : ccl_pkg::STAT_OK);
         r.last    = (k == lim);
         lag_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      ccl_pkg::rsp_type want;
      if (reset) begin
         x_len      = 0;
         y_len      = 0;
         dropped    = 0;
         scale_mode = ccl_pkg::MODE_UNSCALED;
         lag_limit  = 5'd31;
         fail_count = 0;
         lag_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ccl_pkg::CSR_SCALE_MODE)
               scale_mode = csr_wdata[ccl_pkg::MODE_W-1:0];
            else if (csr_index == ccl_pkg::CSR_MAX_LAG)
               lag_limit = csr_wdata[ccl_pkg::MAXLAG_W-1:0];
         end
         if (push && !full) begin
            case (ccl_pkg::cmd_type'(req_command))
               ccl_pkg::CMD_PUSH_X: begin
                  if (x_len >= DEPTH) dropped = 1;
                  else begin
                     x_re[x_len] = req_sample_re;
                     x_im[x_len] = req_sample_im;
                     x_len++;
                  end
               end
               ccl_pkg::CMD_PUSH_Y: begin
                  if (y_len >= DEPTH) dropped = 1;
                  else begin
                     y_re[y_len] = req_sample_re;
                     y_im[y_len] = req_sample_im;
                     y_len++;
                  end
               end
               ccl_pkg::CMD_COMPUTE: queue_lag_run();
               default: begin
                  x_len   = 0;
                  y_len   = 0;
                  dropped = 0;
               end
            endcase
         end
         if (pop && !empty) begin
            if (lag_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result lag %0d", $realtime, rsp_lag);
            end else begin
               want = lag_q.pop_front();
               if (rsp_lag !== want.lag || rsp_corr_re !== want.corr_re ||
                   rsp_corr_im !== want.corr_im || rsp_status !== want.status ||
                   rsp_last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch exp lag %0d re %0d im %0d st %0d last %0b,",
                               " got lag %0d re %0d im %0d st %0d last %0b"},
                        $realtime, want.lag, want.corr_re, want.corr_im, want.status,
                        want.last, rsp_lag, rsp_corr_re, rsp_corr_im, rsp_status, rsp_last);
               end
            end
         end
      end
      pending = lag_q.size();
   end

endmodule

`default_nettype wire

### test/tb_cross_correlation_lags.sv
// ----------------------------------------------------------------------------
// tb_cross_correlation_lags
// Drives sample loads, computes and clears into the correlation engine under
// random idling and a long result back-pressure; a checker predicts each lag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_cross_correlation_lags;

   localparam int CSR_DW = ccl_pkg::CSR_DATA_W;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // item side
   logic                 push = 1'b0;
   logic                 full;
   logic [1:0]           req_command = ccl_pkg::CMD_CLEAR;
   logic signed [15:0]   req_sample_re = '0;
   logic signed [15:0]   req_sample_im = '0;
   // result side
   logic                 empty;
   logic                 pop = 1'b0;
   logic signed [ccl_pkg::LAG_W-1:0]  rsp_lag;
   logic signed [ccl_pkg::CORR_W-1:0] rsp_corr_re, rsp_corr_im;
   logic [ccl_pkg::STATUS_W-1:0]      rsp_status;
   logic                 rsp_last;
   // register port
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ccl_pkg::CSR_IDX_W-1:0] csr_index = ccl_pkg::CSR_SCALE_MODE;
   logic [CSR_DW-1:0]    csr_wdata = '0;

   int fail_count, pending;
   bit no_idle   = 0;   // both sides run flat out while set
   bit hold_req  = 0;   // asks the result side for a long hold-off
   int hold_left = 0;
   int rand_items = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cross_correlation_lags dut (
      .clock, .reset, .push, .full, .req_command, .req_sample_re, .req_sample_im,
      .empty, .pop, .rsp_lag, .rsp_corr_re, .rsp_corr_im, .rsp_status, .rsp_last,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   ccl_checker chk (
      .clock, .reset, .push, .full, .req_command, .req_sample_re, .req_sample_im,
      .empty, .pop, .rsp_lag, .rsp_corr_re, .rsp_corr_im, .rsp_status, .rsp_last,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata, .fail_count, .pending
   );

   // result side: random idling, or a counted hold-off when asked
   always @(negedge clock) begin
      if (reset) pop = 1'b0;
      else if (hold_left > 0) begin
         pop = 1'b0;
         hold_left--;
      end else if (hold_req) begin
         pop       = 1'b0;
         hold_left = 3000;
         hold_req  = 0;
      end else
         pop = no_idle || ($urandom_range(99) >= 17);
   end

   // all tasks start and finish on a falling edge
   task automatic send_item(ccl_pkg::cmd_type cmd, logic [15:0] re, logic [15:0] im);
      if (!no_idle)
         while ($urandom_range(99) < 17) begin
            push = 1'b0;
            @(negedge clock);
         end
      push          = 1'b1;
      req_command   = cmd;
      req_sample_re = re;
      req_sample_im = im;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic write_reg(logic [ccl_pkg::CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait until every lag is back, then let trailing loads and clears drain
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      int r;
      r = int'($urandom_range(7));
      if (r == 0) return 16'h7fff;
      if (r == 1) return 16'h8000;
      return 16'($urandom());
   endfunction

   task automatic load_seq(ccl_pkg::cmd_type cmd, int n);
      repeat (n) send_item(cmd, pick_sample(), pick_sample());
   endtask

   // well-formed block: clear, both loads in random order, compute
   task automatic rand_block();
      int nx, ny;
      nx = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 14));
      ny = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 14));
      send_item(ccl_pkg::CMD_CLEAR, 16'($urandom()), 16'($urandom()));
      if ($urandom_range(1)) begin
         load_seq(ccl_pkg::CMD_PUSH_X, nx);
         load_seq(ccl_pkg::CMD_PUSH_Y, ny);
      end else begin
         load_seq(ccl_pkg::CMD_PUSH_Y, ny);
         load_seq(ccl_pkg::CMD_PUSH_X, nx);
      end
      send_item(ccl_pkg::CMD_COMPUTE, 16'($urandom()), 16'($urandom()));
      rand_items += nx + ny + 2;
   endtask

   initial begin
      int phase;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: empty run, extreme samples, every mode, lag extremes
      write_reg(ccl_pkg::CSR_MAX_LAG, 5'd3);
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      send_item(ccl_pkg::CMD_PUSH_X, 16'h7fff, 16'h7fff);
      send_item(ccl_pkg::CMD_PUSH_X, 16'h8000, 16'h8000);
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);          // y still empty
      send_item(ccl_pkg::CMD_PUSH_Y, 16'h8000, 16'h7fff);
      send_item(ccl_pkg::CMD_PUSH_Y, 16'h7fff, 16'h8000);
      send_item(ccl_pkg::CMD_PUSH_Y, 16'h8000, 16'h8000);
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      settle();
      write_reg(ccl_pkg::CSR_SCALE_MODE, CSR_DW'(ccl_pkg::MODE_BIASED));
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      settle();
      write_reg(ccl_pkg::CSR_SCALE_MODE, CSR_DW'(ccl_pkg::MODE_UNBIASED));
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      settle();
      write_reg(ccl_pkg::CSR_SCALE_MODE, CSR_DW'(3));        // unused code acts unscaled
      write_reg(ccl_pkg::CSR_MAX_LAG, 5'd0);                 // single lag 0
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      settle();
      write_reg(ccl_pkg::CSR_MAX_LAG, 5'd31);                // lags far beyond N give zero
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      send_item(ccl_pkg::CMD_CLEAR, 16'hffff, 16'hffff);
      send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      settle();

      // back-pressure: results pile up while computes keep coming
      write_reg(ccl_pkg::CSR_SCALE_MODE, CSR_DW'(ccl_pkg::MODE_UNSCALED));
      write_reg(ccl_pkg::CSR_MAX_LAG, 5'd31);
      hold_req = 1;
      load_seq(ccl_pkg::CMD_PUSH_X, 4);
      load_seq(ccl_pkg::CMD_PUSH_Y, 3);
      repeat (12) send_item(ccl_pkg::CMD_COMPUTE, 16'h0, 16'h0);
      settle();

      // random phases, each under its own register setting
      phase = 0;
      while (rand_items < 410) begin
         case ($urandom_range(5))
            0:       write_reg(ccl_pkg::CSR_MAX_LAG, 5'd0);
            1:       write_reg(ccl_pkg::CSR_MAX_LAG, 5'd31);
            default: write_reg(ccl_pkg::CSR_MAX_LAG, CSR_DW'($urandom_range(1, 8)));
         endcase
         write_reg(ccl_pkg::CSR_SCALE_MODE, CSR_DW'($urandom_range(3)));
         no_idle = (phase == 3);
         repeat ($urandom_range(1, 3)) begin
            rand_block();
            // noise: stray items of any kind
            repeat ($urandom_range(0, 3)) begin
               send_item(ccl_pkg::cmd_type'($urandom_range(3)), pick_sample(), pick_sample());
               rand_items++;
            end
         end
         settle();
         phase++;
      end
      no_idle = 0;

      settle();
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
